// ===== sv/ldst_pkg.sv =====
// Package: shared types and constants for the lamp dimmer with sleep timer.
package ldst_pkg;

  // Request kinds on the input channel
  typedef enum logic [1:0] {
    KIND_MINUS      = 2'd0,
    KIND_PLUS       = 2'd1,
    KIND_IND_TICK   = 2'd2,
    KIND_SLEEP_TICK = 2'd3
  } kind_t;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 10;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_LEVEL   = 3'd0,
    REG_DUTY_STEP   = 3'd1,
    REG_IND_TICKS   = 3'd2,
    REG_REPEAT_PT   = 3'd3,
    REG_SLEEP_UNIT  = 3'd4,
    REG_SLEEP_LONG  = 3'd5
  } cfg_reg_t;

  // Reset values of the configuration registers
  localparam logic [3:0] RST_MAX_LEVEL  = 4'd10;
  localparam logic [7:0] RST_DUTY_STEP  = 8'd102;
  localparam logic [4:0] RST_IND_TICKS  = 5'd20;
  localparam logic [4:0] RST_REPEAT_PT  = 5'd10;
  localparam logic [7:0] RST_SLEEP_UNIT = 8'd50;
  localparam logic [9:0] RST_SLEEP_LONG = 10'd300;

  localparam logic [9:0] SLEEP_MAX = 10'd1023;

  typedef struct packed {
    logic [3:0] max_level;
    logic [7:0] duty_step;
    logic [4:0] ind_ticks;
    logic [4:0] repeat_pt;
    logic [7:0] sleep_unit;
    logic [9:0] sleep_long;
  } cfg_t;

  typedef struct packed {
    kind_t kind;
    logic  minus_held;
    logic  plus_held;
  } item_t;

  // Indicator lamps
  typedef struct packed {
    logic blue;
    logic green;
    logic red;
  } leds_t;

  typedef struct packed {
    logic [3:0]  level;
    logic [11:0] duty;
    logic        menu;
    logic [2:0]  choice;
    logic [4:0]  ind_cnt;
    logic        ind_run;
    logic [9:0]  slp_cnt;
    logic        slp_run;
    leds_t       leds;
  } state_t;

endpackage

// ===== sv/ldst_if.sv =====
// Interfaces: input request channel and result channel.
interface ldst_in_if;
  import ldst_pkg::*;
  logic  valid;
  logic  ready;
  kind_t kind;
  logic  minus_held;
  logic  plus_held;

  modport source (output valid, output kind, output minus_held, output plus_held,
                  input ready);
  modport sink   (input valid, input kind, input minus_held, input plus_held,
                  output ready);
endinterface

interface ldst_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] duty;
  logic [3:0]  level;
  logic        red_led;
  logic        green_lamp;
  logic        blue_lamp;
  logic        in_menu;
  logic        sleep_active;

  modport source (output valid, output duty, output level, output red_led,
                  output green_lamp, output blue_lamp, output in_menu,
                  output sleep_active, input ready);
  modport sink   (input valid, input duty, input level, input red_led,
                  input green_lamp, input blue_lamp, input in_menu,
                  input sleep_active, output ready);
endinterface

// ===== sv/ldst_cfg_regs.sv =====
// Configuration register bank written through a plain write port.
module ldst_cfg_regs
  import ldst_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r, cfg_nxt;

  // Register decode; writes beyond the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        REG_MAX_LEVEL:  cfg_nxt.max_level  = cfg_data[3:0];
        REG_DUTY_STEP:  cfg_nxt.duty_step  = cfg_data[7:0];
        REG_IND_TICKS:  cfg_nxt.ind_ticks  = cfg_data[4:0];
        REG_REPEAT_PT:  cfg_nxt.repeat_pt  = cfg_data[4:0];
        REG_SLEEP_UNIT: cfg_nxt.sleep_unit = cfg_data[7:0];
        REG_SLEEP_LONG: cfg_nxt.sleep_long = cfg_data[9:0];
        default:        cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_level  <= RST_MAX_LEVEL;
      cfg_r.duty_step  <= RST_DUTY_STEP;
      cfg_r.ind_ticks  <= RST_IND_TICKS;
      cfg_r.repeat_pt  <= RST_REPEAT_PT;
      cfg_r.sleep_unit <= RST_SLEEP_UNIT;
      cfg_r.sleep_long <= RST_SLEEP_LONG;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== sv/ldst_step.sv =====
// Next-state logic: applies one request to the dimmer state.
module ldst_step
  import ldst_pkg::*;
#(
  parameter int SLEEP_CHOICES = 5
)
(
  input  cfg_t   cfg,
  input  item_t  item,
  input  state_t st,
  output state_t nx
);

  localparam logic [2:0] CHOICE_LAST = 3'(SLEEP_CHOICES);

  logic        set_lvl;
  logic [3:0]  lvl_sel;
  logic [3:0]  lvl_up;
  logic [3:0]  lvl_dn;
  logic [10:0] slp_prod;
  logic [9:0]  slp_load;
  logic [2:0]  choice_nx;
  logic [3:0]  ind_menu;

  // Saturating level steps
  assign lvl_up = (st.level < cfg.max_level) ? st.level + 4'd1 : st.level;
  assign lvl_dn = (st.level != 4'd0) ? st.level - 4'd1 : 4'd0;

  // Sleep count loaded when leaving the menu
  assign slp_prod = 11'(st.choice) * 11'(cfg.sleep_unit);
  always_comb begin
    if (st.choice < CHOICE_LAST) begin
      slp_load = (slp_prod > 11'(SLEEP_MAX)) ? SLEEP_MAX : slp_prod[9:0];
    end else begin
      slp_load = cfg.sleep_long;
    end
  end

  // Menu choice step with wrap, and its blink count
  assign choice_nx = (st.choice < CHOICE_LAST) ? st.choice + 3'd1 : 3'd1;
  assign ind_menu  = {choice_nx, 1'b0} - 4'd1;

  always_comb begin
    nx      = st;
    set_lvl = 1'b0;
    lvl_sel = st.level;
    if ((item.kind == KIND_MINUS || item.kind == KIND_PLUS) &&
        item.minus_held && item.plus_held) begin
      // Both buttons: enter the menu
      nx.ind_run    = 1'b0;
      nx.leds.red   = 1'b0;
      nx.leds.green = 1'b0;
      if (!st.menu) begin
        nx.slp_run = 1'b0;
        nx.choice  = 3'd1;
        nx.ind_cnt = 5'd1;
        nx.ind_run = 1'b1;
      end
      nx.menu = 1'b1;
    end else begin
      case (item.kind)
        KIND_MINUS: begin
          if (st.menu) begin
            nx.menu    = 1'b0;
            nx.slp_cnt = slp_load;
            nx.slp_run = 1'b1;
          end else begin
            set_lvl       = 1'b1;
            lvl_sel       = lvl_dn;
            nx.leds.green = 1'b0;
            nx.leds.red   = 1'b1;
            nx.ind_cnt    = cfg.ind_ticks;
            nx.ind_run    = 1'b1;
          end
        end
        KIND_PLUS: begin
          if (st.menu) begin
            nx.choice    = choice_nx;
            nx.leds.blue = 1'b0;
            nx.ind_cnt   = 5'(ind_menu);
            nx.ind_run   = 1'b1;
          end else begin
            set_lvl       = 1'b1;
            lvl_sel       = lvl_up;
            nx.leds.red   = 1'b0;
            nx.leds.green = 1'b1;
            nx.ind_cnt    = cfg.ind_ticks;
            nx.ind_run    = 1'b1;
          end
        end
        KIND_IND_TICK: begin
          if (st.ind_run) begin
            if (!st.menu) begin
              if (st.ind_cnt == 5'd0) begin
                nx.leds.red   = 1'b0;
                nx.leds.green = 1'b0;
                nx.ind_run    = 1'b0;
              end
              // Held plus repeats the raise
              if (st.ind_cnt == cfg.repeat_pt && item.plus_held) begin
                set_lvl    = 1'b1;
                lvl_sel    = lvl_up;
                nx.ind_cnt = cfg.ind_ticks;
              end else if (st.ind_cnt != 5'd0) begin
                nx.ind_cnt = st.ind_cnt - 5'd1;
              end
            end else begin
              nx.leds.blue = ~st.leds.blue;
              if (st.ind_cnt == 5'd0) begin
                nx.ind_run = 1'b0;
              end else begin
                nx.ind_cnt = st.ind_cnt - 5'd1;
              end
            end
          end
        end
        KIND_SLEEP_TICK: begin
          if (st.slp_run) begin
            if (st.slp_cnt == 10'd0) begin
              nx.level   = 4'd0;
              nx.duty    = 12'd0;
              nx.slp_run = 1'b0;
            end else begin
              nx.slp_cnt = st.slp_cnt - 10'd1;
            end
          end
        end
        default: nx = st;
      endcase
    end
    // Duty follows the new level with the current step
    if (set_lvl) begin
      nx.level = lvl_sel;
      nx.duty  = 12'(cfg.duty_step) * 12'(lvl_sel);
    end
  end

endmodule

// ===== sv/lamp_dimmer_sleep_timer_core.sv =====
// Top level: lamp dimmer with sleep timer.
// Path: a request goes through the input register, then the result register.
// Throughput: one request per cycle; the state update happens as a request leaves
// the input register, and a stalled result holds that register.
// Reset (synchronous, rst_n low): state and lamps clear, registers load defaults.
module lamp_dimmer_sleep_timer_core
  import ldst_pkg::*;
#(
  parameter int SLEEP_CHOICES = 5
)
(
  input  logic                  clk,
  input  logic                  rst_n,
  ldst_in_if.sink               in_ch,
  ldst_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t   cfg;
  item_t  item_r;
  logic   s1_vld_r;
  logic   out_vld_r;
  logic   adv;
  logic   in_rdy;
  state_t st_r;
  state_t st_nxt;

  ldst_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ldst_step #(.SLEEP_CHOICES(SLEEP_CHOICES)) u_step (
    .cfg  (cfg),
    .item (item_r),
    .st   (st_r),
    .nx   (st_nxt)
  );

  // Handshake: input stage moves on when the result register is free
  assign adv    = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_rdy = !s1_vld_r || adv;
  assign in_ch.ready = in_rdy;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_rdy) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_rdy && in_ch.valid) begin
      item_r.kind       <= in_ch.kind;
      item_r.minus_held <= in_ch.minus_held;
      item_r.plus_held  <= in_ch.plus_held;
    end
  end

  // Dimmer state, updated once per request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_ch.ready) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_ch.duty         <= st_nxt.duty;
      out_ch.level        <= st_nxt.level;
      out_ch.red_led      <= st_nxt.leds.red;
      out_ch.green_lamp   <= st_nxt.leds.green;
      out_ch.blue_lamp    <= st_nxt.leds.blue;
      out_ch.in_menu      <= st_nxt.menu;
      out_ch.sleep_active <= st_nxt.slp_run;
    end
  end

  assign out_ch.valid = out_vld_r;

endmodule
